>>> rtl/core/epid_pkg.sv
// ----------------------------------------------------------------------------
// epid_pkg
// Shared types and constants for the encoder PID speed controller.
// ----------------------------------------------------------------------------
package epid_pkg;

	// Configuration register map
	localparam int CFG_IDX_W = 3;
	localparam int GAIN_W    = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_PROP     = 3'd0,
		CFG_GAIN_INTEG    = 3'd1,
		CFG_GAIN_DERIV    = 3'd2,
		CFG_SPEED_INVERT  = 3'd3,
		CFG_FORWARD_LEVEL = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_ENC    = 2'd0,
		OP_TICK   = 2'd1,
		OP_TARGET = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_ACK  = 1'b1
	} kind_t;

	// Reset values of the configuration registers
	localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 10'd30;
	localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 10'd0;
	localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 10'd100;
	localparam logic              INVERT_RST     = 1'b0;
	localparam logic              FWD_LEVEL_RST  = 1'b1;

	// Field widths
	localparam int CNT_W    = 16;
	localparam int TGT_W    = 8;
	localparam int ERR_W    = 16;
	localparam int DIFF_W   = 17;
	localparam int INTEG_W  = 11;
	localparam int DUTY_W   = 13;
	localparam int CORR_W   = 16;

	// Target mapping
	localparam int TGT_SCALE_NUM = 90;
	localparam int TGT_SCALE_SH  = 7;
	localparam int TGT_DEADBAND  = 12;
	localparam int TGT_LIMIT     = 90;

	// PID limits
	localparam int INTEG_LIMIT = 1000;
	localparam int ERR_MAX     = 32767;
	localparam int ERR_MIN     = -32768;

	// Duty shaping
	localparam int DUTY_OFF_BELOW = 100;
	localparam int DUTY_MIN_RUN   = 1000;
	localparam int DUTY_MAX       = 7500;

	// Signed drive: present duty plus correction
	localparam int DRV_W = 18;

	// Product and sum widths
	localparam int PPROP_W = GAIN_W + 1 + ERR_W;
	localparam int PDER_W  = GAIN_W + 1 + DIFF_W;
	localparam int PINT_W  = GAIN_W + 1 + INTEG_W;
	localparam int SUM_W   = PDER_W + 1;

	// Divide by ten: q = (n * DIV_M) >> DIV_SHIFT, exact for any DIV_N_W-bit n.
	// The reciprocal is split in two so that each partial product stays narrow.
	localparam int DIV_N_W    = 27;
	localparam int DIV_Q_W    = 24;
	localparam int DIV_SHIFT  = 30;
	localparam int DIV_SPLIT  = 14;
	localparam int DIV_M      = 107374183;
	localparam int DIV_M_LO   = DIV_M % (1 << DIV_SPLIT);
	localparam int DIV_M_HI   = DIV_M / (1 << DIV_SPLIT);
	localparam int DIV_LO_W   = DIV_N_W + DIV_SPLIT;
	localparam int DIV_HI_W   = DIV_N_W + 13;
	localparam int DIV_FULL_W = DIV_HI_W + DIV_SPLIT;

	// Control that travels with an item down the pipe
	typedef struct packed {
		logic                    valid;
		kind_t                   kind;
		logic signed [TGT_W-1:0] target;
	} pipe_ctl_t;

endpackage

>>> rtl/core/epid_div10.sv
// ----------------------------------------------------------------------------
// epid_div10
// Two-stage unsigned divide by ten by reciprocal multiplication.
// ----------------------------------------------------------------------------
module epid_div10 import epid_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [DIV_N_W-1:0] num,
	output logic [DIV_Q_W-1:0] quo
);

	logic [DIV_LO_W-1:0]   plo_s5;
	logic [DIV_HI_W-1:0]   phi_s5;
	logic [DIV_FULL_W-1:0] full;

	// partial products against the low and high halves of the reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			plo_s5 <= DIV_LO_W'(num) * DIV_LO_W'(DIV_M_LO);
			phi_s5 <= DIV_HI_W'(num) * DIV_HI_W'(DIV_M_HI);
		end
	end

	assign full = {phi_s5, DIV_SPLIT'(0)} + DIV_FULL_W'(plo_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= full[DIV_SHIFT +: DIV_Q_W];
		end
	end

endmodule

>>> rtl/core/encoder_pid_motor_speed.sv
// ----------------------------------------------------------------------------
// encoder_pid_motor_speed - quadrature encoder count and PID speed loop, one motor
// Pipe: a request passes s1 to s6 and the output register before its result is presented.
// Throughput: one request per cycle; stalls only while a result is held on m_tready.
// Reset: arst_n clears counts, loop state and pipe; registers return to defaults.
// ----------------------------------------------------------------------------
module encoder_pid_motor_speed import epid_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	// request stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // enc_a[0], enc_b[1], command_byte[9:2], zero[15:10]
	input  logic [1:0]           s_tuser,   // op[1:0]
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // duty[12:0], dir_level[13], correction[29:14],
	                                        // target_value[37:30], zero[39:38]
	output logic                 m_tuser    // kind[0]
);

	// ------------------------------------------------------------------------
	// Pipe overview
	//   s1 : request register; loop state (count, target, integral,
	//        last error) is updated here as the request leaves s1
	//   s2 : error, difference and integral of a tick
	//   s3 : three gain products
	//   s4 : PID sum, split into sign and magnitude
	//   s5/s6 : divide by ten (epid_div10)
	//   out : drive/duty feedback loop and the result register
	// All stages step together on adv; s1 refills whenever it is empty.
	// ------------------------------------------------------------------------

	// configuration
	logic [GAIN_W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
	logic              speed_invert_q, forward_level_q;

	// loop state
	logic signed [CNT_W-1:0]   edge_count_q;
	logic                      prev_a_q, prev_b_q;
	logic signed [TGT_W-1:0]   target_q;
	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic [DUTY_W-1:0]         duty_q;
	logic                      dir_q;

	// pipe
	logic                      adv;
	logic                      valid_s1;
	op_t                       op_s1;
	logic                      a_s1, b_s1;
	logic signed [TGT_W-1:0]   cmd_s1;
	pipe_ctl_t                 ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic signed [ERR_W-1:0]   err_s2;
	logic signed [DIFF_W-1:0]  diff_s2;
	logic signed [INTEG_W-1:0] integ_s2;
	logic signed [PPROP_W-1:0] pprop_s3;
	logic signed [PDER_W-1:0]  pder_s3;
	logic signed [PINT_W-1:0]  pint_s3;
	logic [DIV_N_W-1:0]        mag_s4;
	logic                      neg_s4, neg_s5, neg_s6;
	logic [DIV_Q_W-1:0]        quo_s6;

	// output register
	logic                      out_valid_q;
	kind_t                     out_kind_q;
	logic [DUTY_W-1:0]         out_duty_q;
	logic                      out_dir_q;
	logic signed [CORR_W-1:0]  out_corr_q;
	logic signed [TGT_W-1:0]   out_target_q;

	// ------------------------------------------------------------------------
	// Handshake: the whole pipe steps unless a result is held at the output;
	// s1 may still take a request while it is empty.
	// ------------------------------------------------------------------------
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv || !valid_s1;

	logic fire_s1;
	assign fire_s1 = valid_s1 && adv;

	// ------------------------------------------------------------------------
	// Configuration writes
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q     <= GAIN_PROP_RST;
			gain_integ_q    <= GAIN_INTEG_RST;
			gain_deriv_q    <= GAIN_DERIV_RST;
			speed_invert_q  <= INVERT_RST;
			forward_level_q <= FWD_LEVEL_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_GAIN_PROP:     gain_prop_q     <= cfg_data;
				CFG_GAIN_INTEG:    gain_integ_q    <= cfg_data;
				CFG_GAIN_DERIV:    gain_deriv_q    <= cfg_data;
				CFG_SPEED_INVERT:  speed_invert_q  <= cfg_data[0];
				CFG_FORWARD_LEVEL: forward_level_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// s1: request register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= op_t'(s_tuser);
			a_s1   <= s_tdata[0];
			b_s1   <= s_tdata[1];
			cmd_s1 <= s_tdata[9:2];
		end
	end

	// ------------------------------------------------------------------------
	// s1 logic: encoder step, target mapping, error and integral
	// ------------------------------------------------------------------------
	logic                      up, dn;
	logic signed [CNT_W-1:0]   edge_nxt;
	logic signed [14:0]        cmd_scaled;
	logic signed [14:0]        cmd_rnd;
	logic signed [TGT_W-1:0]   tgt_div;
	logic signed [TGT_W-1:0]   tgt_new;
	logic signed [CNT_W:0]     speed;
	logic signed [CNT_W+1:0]   err_wide;
	logic signed [ERR_W-1:0]   err;
	logic signed [ERR_W:0]     integ_wide;
	logic signed [INTEG_W-1:0] integ_new;
	logic signed [DIFF_W-1:0]  diff;

	assign up       = a_s1 ^ prev_b_q;
	assign dn       = b_s1 ^ prev_a_q;
	assign edge_nxt = edge_count_q + CNT_W'(up) - CNT_W'(dn);

	// command * 90 / 128, truncated toward zero (bias negatives before the shift)
	assign cmd_scaled = 15'(cmd_s1) * 15'(TGT_SCALE_NUM);
	assign cmd_rnd    = cmd_scaled[14] ? cmd_scaled + 15'((1 << TGT_SCALE_SH) - 1) : cmd_scaled;
	assign tgt_div    = TGT_W'(cmd_rnd >>> TGT_SCALE_SH);

	always_comb begin
		if (tgt_div < TGT_W'(TGT_DEADBAND) && tgt_div > -TGT_W'(TGT_DEADBAND))
			tgt_new = '0;
		else if (tgt_div > TGT_W'(TGT_LIMIT))
			tgt_new = TGT_W'(TGT_LIMIT);
		else if (tgt_div < -TGT_W'(TGT_LIMIT))
			tgt_new = -TGT_W'(TGT_LIMIT);
		else
			tgt_new = tgt_div;
	end

	// speed is the count, negated for a mirrored motor
	assign speed    = speed_invert_q ? -(CNT_W+1)'(edge_count_q) : (CNT_W+1)'(edge_count_q);
	assign err_wide = (CNT_W+2)'(target_q) - (CNT_W+2)'(speed);

	always_comb begin
		if (err_wide > (CNT_W+2)'(ERR_MAX))
			err = ERR_W'(ERR_MAX);
		else if (err_wide < (CNT_W+2)'(ERR_MIN))
			err = ERR_W'(ERR_MIN);
		else
			err = err_wide[ERR_W-1:0];
	end

	assign integ_wide = (ERR_W+1)'(integ_q) + (ERR_W+1)'(err);

	always_comb begin
		if (integ_wide > (ERR_W+1)'(INTEG_LIMIT))
			integ_new = INTEG_W'(INTEG_LIMIT);
		else if (integ_wide < -(ERR_W+1)'(INTEG_LIMIT))
			integ_new = -INTEG_W'(INTEG_LIMIT);
		else
			integ_new = integ_wide[INTEG_W-1:0];
	end

	assign diff = DIFF_W'(err) - DIFF_W'(prev_err_q);

	// loop state moves only as a request leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
			prev_a_q     <= 1'b0;
			prev_b_q     <= 1'b0;
			target_q     <= '0;
			prev_err_q   <= '0;
			integ_q      <= '0;
		end else if (fire_s1) begin
			case (op_s1)
				OP_ENC: begin
					edge_count_q <= edge_nxt;
					prev_a_q     <= a_s1;
					prev_b_q     <= b_s1;
				end
				OP_TARGET: begin
					target_q <= tgt_new;
				end
				OP_TICK: begin
					integ_q      <= integ_new;
					prev_err_q   <= err;
					edge_count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// s2 .. s6 control and payload
	// ------------------------------------------------------------------------
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] sum_abs;

	assign sum = SUM_W'(pprop_s3) + SUM_W'(pder_s3) + SUM_W'(pint_s3);
	assign sum_abs = sum[SUM_W-1] ? -sum : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (adv) begin
			ctl_s2.valid  <= valid_s1 && (op_s1 == OP_TICK || op_s1 == OP_TARGET);
			ctl_s2.kind   <= (op_s1 == OP_TARGET) ? KIND_ACK : KIND_TICK;
			ctl_s2.target <= (op_s1 == OP_TARGET) ? tgt_new : target_q;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s2   <= err;
			diff_s2  <= diff;
			integ_s2 <= integ_new;
			pprop_s3 <= $signed({1'b0, gain_prop_q}) * err_s2;
			pder_s3  <= $signed({1'b0, gain_deriv_q}) * diff_s2;
			pint_s3  <= $signed({1'b0, gain_integ_q}) * integ_s2;
			neg_s4   <= sum[SUM_W-1];
			mag_s4   <= sum_abs[DIV_N_W-1:0];
			neg_s5   <= neg_s4;
			neg_s6   <= neg_s5;
		end
	end

	// ------------------------------------------------------------------------
	// s5/s6: magnitude / 10
	// ------------------------------------------------------------------------
	epid_div10 u_div10 (
		.clk (clk),
		.en  (adv),
		.num (mag_s4),
		.quo (quo_s6)
	);

	// ------------------------------------------------------------------------
	// Output stage: correction, signed drive and duty shaping
	// ------------------------------------------------------------------------
	logic signed [DIV_Q_W:0]  corr_wide;
	logic signed [CORR_W-1:0] corr;
	logic signed [DRV_W-1:0]  drive_base;
	logic signed [DRV_W-1:0]  drive;
	logic [DRV_W-1:0]         drive_mag;
	logic [DUTY_W-1:0]        duty_new;
	logic                     dir_new;

	assign corr_wide = neg_s6 ? -(DIV_Q_W+1)'(quo_s6) : (DIV_Q_W+1)'(quo_s6);

	always_comb begin
		if (corr_wide > (DIV_Q_W+1)'(ERR_MAX))
			corr = CORR_W'(ERR_MAX);
		else if (corr_wide < (DIV_Q_W+1)'(ERR_MIN))
			corr = CORR_W'(ERR_MIN);
		else
			corr = corr_wide[CORR_W-1:0];
	end

	// drive_base is negative when the pin currently shows the backward level
	assign drive_base = (dir_q != forward_level_q) ? -DRV_W'(duty_q) : DRV_W'(duty_q);
	assign drive      = drive_base + DRV_W'(corr);
	assign dir_new    = drive[DRV_W-1] ? !forward_level_q : forward_level_q;
	assign drive_mag  = drive[DRV_W-1] ? DRV_W'(-drive) : DRV_W'(drive);

	always_comb begin
		if (drive_mag < DRV_W'(DUTY_OFF_BELOW))
			duty_new = '0;
		else if (drive_mag < DRV_W'(DUTY_MIN_RUN))
			duty_new = DUTY_W'(DUTY_MIN_RUN);
		else if (drive_mag > DRV_W'(DUTY_MAX))
			duty_new = DUTY_W'(DUTY_MAX);
		else
			duty_new = drive_mag[DUTY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q      <= '0;
			dir_q       <= FWD_LEVEL_RST;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_s6.valid;
			if (ctl_s6.valid && ctl_s6.kind == KIND_TICK) begin
				duty_q <= duty_new;
				dir_q  <= dir_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_kind_q   <= ctl_s6.kind;
			out_target_q <= ctl_s6.target;
			if (ctl_s6.kind == KIND_TICK) begin
				out_duty_q <= duty_new;
				out_dir_q  <= dir_new;
				out_corr_q <= corr;
			end else begin
				// target acknowledgement carries only the target
				out_duty_q <= '0;
				out_dir_q  <= 1'b0;
				out_corr_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {2'b00, out_target_q, out_corr_q, out_dir_q, out_duty_q};

endmodule

>>> verif/epid_speed_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epid_speed_checker
// Follows the request and result streams of the speed controller, keeps its
// own copy of the encoder count and PID loop, and flags every differing result.
// ----------------------------------------------------------------------------
module epid_speed_checker import epid_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [15:0]          s_tdata,   // enc_a[0], enc_b[1], command_byte[9:2], zero[15:10]
	input  logic [1:0]           s_tuser,   // op[1:0]
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [39:0]          m_tdata,   // duty[12:0], dir_level[13], correction[29:14],
	                                        // target_value[37:30], zero[39:38]
	input  logic                 m_tuser,   // kind[0]
	output int                   fail_count,
	output int                   pending
);

	localparam int GAIN_DIV = 10;

	typedef struct {
		kind_t                    kind;
		logic [DUTY_W-1:0]        duty;
		logic                     dir_level;
		logic signed [CORR_W-1:0] correction;
		logic signed [TGT_W-1:0]  target_value;
	} motor_result_t;

	motor_result_t due_results[$];
	motor_result_t want;

	// loop settings
	logic [GAIN_W-1:0] kp, ki, kd;
	logic              invert, fwd_level;

	// loop state
	logic signed [CNT_W-1:0]   enc_count;
	logic                      last_a, last_b;
	logic signed [TGT_W-1:0]   target;
	logic signed [ERR_W-1:0]   last_err;
	logic signed [INTEG_W-1:0] integ;
	logic [DUTY_W-1:0]         duty;
	logic                      dir;

	function automatic int clip(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic check_field(input string name, input logic signed [CORR_W:0] exp_val,
	                           input logic signed [CORR_W:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			fail_count++;
		end
	endtask

	task automatic run_motor_event(input op_t op, input logic a, input logic b,
	                               input logic signed [TGT_W-1:0] cmd);
		int            speed, err, diff, sum, corr, drive, mag, t;
		logic          back;
		motor_result_t res;
		back             = ~fwd_level;
		res.kind         = KIND_ACK;
		res.duty         = '0;
		res.dir_level    = 1'b0;
		res.correction   = '0;
		res.target_value = '0;
		case (op)
			OP_ENC: begin
				enc_count = enc_count + CNT_W'(a ^ last_b) - CNT_W'(b ^ last_a);
				last_a    = a;
				last_b    = b;
			end
			OP_TARGET: begin
				t = int'(cmd) * TGT_SCALE_NUM / (1 << TGT_SCALE_SH);
				if (t > -TGT_DEADBAND && t < TGT_DEADBAND)
					t = 0;
				target           = TGT_W'(clip(t, -TGT_LIMIT, TGT_LIMIT));
				res.target_value = target;
				due_results.push_back(res);
			end
			OP_TICK: begin
				speed = invert ? -int'(enc_count) : int'(enc_count);
				err   = clip(int'(target) - speed, ERR_MIN, ERR_MAX);
				integ = INTEG_W'(clip(int'(integ) + err, -INTEG_LIMIT, INTEG_LIMIT));
				diff  = err - int'(last_err);
				sum   = int'(kp) * err + int'(kd) * diff + int'(ki) * int'(integ);
				corr  = clip(sum / GAIN_DIV, ERR_MIN, ERR_MAX);
				drive = (dir == back) ? -int'(duty) : int'(duty);
				drive = drive + corr;
				if (drive < 0) begin
					dir = back;
					mag = -drive;
				end else begin
					dir = fwd_level;
					mag = drive;
				end
				if (mag < DUTY_OFF_BELOW)
					duty = '0;
				else if (mag < DUTY_MIN_RUN)
					duty = DUTY_W'(DUTY_MIN_RUN);
				else if (mag > DUTY_MAX)
					duty = DUTY_W'(DUTY_MAX);
				else
					duty = DUTY_W'(mag);
				last_err  = ERR_W'(err);
				enc_count = '0;
				res.kind         = KIND_TICK;
				res.duty         = duty;
				res.dir_level    = dir;
				res.correction   = CORR_W'(corr);
				res.target_value = target;
				due_results.push_back(res);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp         = GAIN_PROP_RST;
			ki         = GAIN_INTEG_RST;
			kd         = GAIN_DERIV_RST;
			invert     = INVERT_RST;
			fwd_level  = FWD_LEVEL_RST;
			enc_count  = '0;
			last_a     = 1'b0;
			last_b     = 1'b0;
			target     = '0;
			last_err   = '0;
			integ      = '0;
			duty       = '0;
			dir        = FWD_LEVEL_RST;
			fail_count = 0;
			due_results.delete();
			pending <= 0;
		end else begin
			// results leave before new requests join, so an unexpected one is never masked
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("result with no request outstanding: tdata %h, tuser %b",
					       m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("kind", want.kind, m_tuser);
					check_field("duty", want.duty, m_tdata[12:0]);
					check_field("dir_level", want.dir_level, m_tdata[13]);
					check_field("correction", want.correction, $signed(m_tdata[29:14]));
					check_field("target_value", want.target_value, $signed(m_tdata[37:30]));
				end
			end
			if (s_tvalid && s_tready)
				run_motor_event(op_t'(s_tuser), s_tdata[0], s_tdata[1], s_tdata[9:2]);
			if (cfg_wen) begin
				case (cfg_reg_t'(cfg_index))
					CFG_GAIN_PROP:     kp        = cfg_data;
					CFG_GAIN_INTEG:    ki        = cfg_data;
					CFG_GAIN_DERIV:    kd        = cfg_data;
					CFG_SPEED_INVERT:  invert    = cfg_data[0];
					CFG_FORWARD_LEVEL: fwd_level = cfg_data[0];
					default: ;
				endcase
			end
			pending <= due_results.size();
		end
	end

endmodule

>>> verif/tb_encoder_pid_motor_speed.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_encoder_pid_motor_speed
// Drives encoder samples, control ticks and target commands into the speed
// controller under several gain settings, with random gaps on both streams,
// and lets epid_speed_checker compare every result against its own loop model.
// ----------------------------------------------------------------------------
module tb_encoder_pid_motor_speed;
	import epid_pkg::*;

	localparam int QUIET_LIMIT        = 2000;  // cycles with no handshake at all
	localparam int PIPE_DRAIN         = 12;    // time for requests that give no result to leave the pipe
	localparam int SPIN_STEPS         = 50;    // one-way run of clean encoder steps
	localparam int BURST_ITEMS        = 75;
	localparam int CFG_FIRST_UNMAPPED = 5;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0]    cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;   // enc_a[0], enc_b[1], command_byte[9:2], zero[15:10]
	logic [1:0]           s_tuser;   // op[1:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [39:0]          m_tdata;   // duty[12:0], dir_level[13], correction[29:14],
	                                 // target_value[37:30], zero[39:38]
	logic                 m_tuser;   // kind[0]

	int         fail_count;
	int         pending;
	int         quiet;
	bit         tx_calm;   // sender runs without gaps while set
	bit         rx_calm;   // receiver never stalls while set
	logic [1:0] quad_pos;  // Gray position of the encoder levels last sent

	encoder_pid_motor_speed DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	epid_speed_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One request: optional gap with tvalid low, then hold until accepted.
	// tvalid is left high so the next request can follow back to back.
	task automatic send_request(input op_t op, input logic a, input logic b,
	                            input logic [7:0] cmd);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'b0, cmd, b, a};
		do @(posedge clk); while (!s_tready);
	endtask

	// Well-formed quadrature step; positions 0..3 map to ab = 00, 10, 11, 01
	task automatic enc_step(input bit fwd);
		quad_pos = fwd ? quad_pos + 2'd1 : quad_pos - 2'd1;
		send_request(OP_ENC, quad_pos[0] ^ quad_pos[1], quad_pos[1], 8'($urandom));
	endtask

	// Stop sending, wait for every expected result, then let the pipe empty
	// of requests that give no result (encoder samples, unused op).
	task automatic settle;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	// Only called with the block idle. Unused upper bits of the one-bit
	// registers carry noise, and a write to an unmapped index must be ignored.
	task automatic load_settings(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
	                             input logic [GAIN_W-1:0] d, input logic inv,
	                             input logic fwd);
		cfg_wen   <= 1'b1;
		cfg_index <= CFG_GAIN_PROP;
		cfg_data  <= p;
		@(posedge clk);
		cfg_index <= CFG_GAIN_INTEG;
		cfg_data  <= i;
		@(posedge clk);
		cfg_index <= CFG_GAIN_DERIV;
		cfg_data  <= d;
		@(posedge clk);
		cfg_index <= CFG_SPEED_INVERT;
		cfg_data  <= {(GAIN_W-1)'($urandom), inv};
		@(posedge clk);
		cfg_index <= CFG_FORWARD_LEVEL;
		cfg_data  <= {(GAIN_W-1)'($urandom), fwd};
		@(posedge clk);
		cfg_index <= CFG_IDX_W'($urandom_range(CFG_FIRST_UNMAPPED, (1 << CFG_IDX_W) - 1));
		cfg_data  <= GAIN_W'($urandom);
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// Mostly clean encoder motion with a drifting bias, ticks in between,
	// new targets now and then; the rest is glitchy levels and the unused op.
	task automatic random_burst(input int n);
		int lean;
		int pick;
		lean = $urandom_range(0, 100);
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 68)
				enc_step($urandom_range(1, 100) <= lean);
			else if (pick < 82)
				send_request(OP_TICK, 1'($urandom), 1'($urandom), 8'($urandom));
			else if (pick < 90)
				send_request(OP_TARGET, 1'($urandom), 1'($urandom), 8'($urandom));
			else if (pick < 97)
				send_request(OP_ENC, 1'($urandom), 1'($urandom), 8'($urandom));
			else
				send_request(OP_NONE, 1'($urandom), 1'($urandom), 8'($urandom));
			if ($urandom_range(0, 29) == 0)
				lean = $urandom_range(0, 100);
			if ($urandom_range(0, 39) == 0)
				tx_calm = !tx_calm;
		end
	endtask

	// Result side: random stall before each result, with calm stretches
	initial begin
		int stall;
		m_tready <= 1'b0;
		rx_calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
		end
	end

	// Watchdog: a hung stream ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("encoder_pid_motor_speed verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_index <= CFG_GAIN_PROP;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_NONE;
		tx_calm   = 1'b0;
		quad_pos  = 2'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset gains ---
		send_request(OP_NONE, 1'b1, 1'b1, 8'hFF);       // unused op, all ones
		send_request(OP_TARGET, 1'b0, 1'b0, 8'(-128));  // most negative, maps to exactly -90
		send_request(OP_TARGET, 1'b0, 1'b0, 8'd17);     // just inside the deadband
		send_request(OP_TARGET, 1'b0, 1'b0, 8'(-18));   // just outside, negative
		send_request(OP_TARGET, 1'b0, 1'b0, 8'd18);     // just outside, positive
		send_request(OP_TARGET, 1'b0, 1'b0, 8'(-17));
		send_request(OP_TARGET, 1'b0, 1'b0, 8'd127);    // most positive
		repeat (4) enc_step(1'b1);
		send_request(OP_TICK, 1'b0, 1'b0, 8'h00);
		// both levels flip at once: up and down cancel
		send_request(OP_ENC, 1'b1, 1'b1, 8'h00);
		send_request(OP_ENC, 1'b0, 1'b0, 8'h00);
		repeat (4) enc_step(1'b0);
		send_request(OP_TICK, 1'b1, 1'b1, 8'hFF);
		send_request(OP_TICK, 1'b0, 1'b0, 8'h00);       // no motion since the last tick
		send_request(OP_TARGET, 1'b1, 1'b1, 8'h00);
		send_request(OP_TICK, 1'b0, 1'b0, 8'h00);
		send_request(OP_TICK, 1'b0, 1'b0, 8'h00);

		// --- long one-way spins at the largest targets, back to back ---
		tx_calm = 1'b1;
		send_request(OP_TARGET, 1'b0, 1'b0, 8'd127);
		repeat (SPIN_STEPS) enc_step(1'b1);
		send_request(OP_TICK, 1'b0, 1'b0, 8'h00);
		send_request(OP_TARGET, 1'b0, 1'b0, 8'(-128));
		repeat (SPIN_STEPS) enc_step(1'b0);
		send_request(OP_TICK, 1'b0, 1'b0, 8'h00);
		tx_calm = 1'b0;
		random_burst(BURST_ITEMS);
		settle();

		// --- extremes of every register ---
		load_settings('0, '0, '0, 1'b0, 1'b0);
		random_burst(BURST_ITEMS);
		settle();
		load_settings('1, '1, '1, 1'b1, 1'b1);
		random_burst(BURST_ITEMS);
		settle();
		load_settings('1, '0, '0, 1'b0, 1'b0);
		random_burst(BURST_ITEMS);
		settle();
		load_settings('0, '1, '0, 1'b1, 1'b0);
		random_burst(BURST_ITEMS);
		settle();

		// --- moderate gains, where duty lands between the thresholds ---
		repeat (3) begin
			load_settings(GAIN_W'($urandom_range(0, 80)), GAIN_W'($urandom_range(0, 20)),
			              GAIN_W'($urandom_range(0, 120)), 1'($urandom), 1'($urandom));
			random_burst(BURST_ITEMS);
			settle();
		end

		if (fail_count == 0)
			$display("encoder_pid_motor_speed verification clean");
		else
			$display("encoder_pid_motor_speed verification failed");
		$finish;
	end

endmodule
